// File: rtl/spbh_pkg.sv
// Package for the height slicer: sizes, the point word types and the
// register map. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spbh_pkg;

   // Default capacity of the sorting chain.
   localparam int MAX_POINTS = 64;

   // Fixed field widths.
   localparam int HEIGHT_W = 32;
   localparam int IDX_W    = 6;
   localparam int SLICE_W  = 6;
   localparam int THICK_W  = 31;

   // Depth of the queue between the sorting chain and the slicer.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_THICKNESS  = 3'd0;
   localparam logic [THICK_W-1:0]    THICKNESS_RESET = 31'd6554;

   // Input word: one point.
   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height_value;
      logic                       last_point;
   } req_word_type;

   // Result word: one emitted point.
   typedef struct packed {
      logic [IDX_W-1:0]   point_index;
      logic [SLICE_W-1:0] slice_number;
      logic               slice_start;
      logic               points_dropped;
      logic               last_result;
   } rsp_word_type;

   // One stored point inside the sorting chain.
   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic [IDX_W-1:0]           index;
   } cell_type;

   // Word moved from the sorting chain to the slicer.
   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic [IDX_W-1:0]           index;
      logic                       dropped;
      logic                       last;
   } point_word_type;

endpackage

`default_nettype wire

// File: rtl/spbh_sorter.sv
// Front end: accepts points and keeps them in a sorted chain of cells,
// then shifts the sorted set out into the queue. Depends on spbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spbh_sorter #(
   parameter int MAX_POINTS = spbh_pkg::MAX_POINTS
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   input  spbh_pkg::req_word_type     req_data,
   output logic                       req_stall,
   input  wire                        q_full,
   output logic                       q_push,
   output spbh_pkg::point_word_type   q_word
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;

   spbh_pkg::cell_type cell_ff [MAX_POINTS];
   spbh_pkg::cell_type cell_in [MAX_POINTS];
   logic [MAX_POINTS-1:0] valid_ff, valid_in;
   logic [MAX_POINTS-1:0] gt;

   logic accept;
   logic room;
   logic insert;
   spbh_pkg::cell_type key;

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && (state_ff == ST_LOAD);
   assign room      = (count_ff < CNT_W'(MAX_POINTS));
   assign insert    = accept && room;
   assign key.height = req_data.height_value;
   assign key.index  = spbh_pkg::IDX_W'(count_ff);

   // During a drain, the head cell goes to the queue whenever the queue has space.
   assign q_push         = (state_ff == ST_DRAIN) && !q_full;
   assign q_word.height  = cell_ff[0].height;
   assign q_word.index   = cell_ff[0].index;
   assign q_word.dropped = ovf_ff;
   assign q_word.last    = (count_ff == CNT_W'(1));

   // Each cell compares its height with the new point. Empty cells count as
   // greater, and equal heights stay ahead of the new point, which keeps the
   // arrival order among ties.
   always_comb begin
      for (int i = 0; i < MAX_POINTS; i++) begin
         gt[i] = !valid_ff[i] || (cell_ff[i].height > key.height);
      end
   end

   // A cell either keeps its point, takes the new point, takes its lower
   // neighbor's point on insertion, or takes its upper neighbor's on a drain.
   always_comb begin
      for (int i = 0; i < MAX_POINTS; i++) begin
         cell_in[i]  = cell_ff[i];
         valid_in[i] = valid_ff[i];
         if (q_push) begin
            if (i == MAX_POINTS - 1) begin
               valid_in[i] = 1'b0;
            end else begin
               cell_in[i]  = cell_ff[(i == MAX_POINTS - 1) ? i : i + 1];
               valid_in[i] = valid_ff[(i == MAX_POINTS - 1) ? i : i + 1];
            end
         end else if (insert) begin
            if (i > 0 && gt[(i == 0) ? 0 : i - 1]) begin
               cell_in[i]  = cell_ff[(i == 0) ? 0 : i - 1];
               valid_in[i] = valid_ff[(i == 0) ? 0 : i - 1];
            end else if (gt[i]) begin
               cell_in[i]  = key;
               valid_in[i] = 1'b1;
            end
         end
      end
   end

   // Load and drain control.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_point) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (q_push) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // The filled cells always match the point count.
   a_cells_match_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("sorter: filled cells differ from point count");

   // A drain only moves a filled head cell.
   a_push_from_filled: assert property (@(posedge clock) disable iff (reset)
      q_push |-> valid_ff[0])
      else $error("sorter: push from an empty chain");

   // After the last word of a set leaves, the chain is empty and loading.
   a_set_closed: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_word.last) |=> (count_ff == '0 && state_ff == ST_LOAD && !ovf_ff))
      else $error("sorter: set not closed after last word");

endmodule

`default_nettype wire

// File: rtl/spbh_queue.sv
// Short first-in first-out queue between the sorting chain and the slicer.
// Depends on spbh_pkg for the word type and the depth.
`timescale 1ns / 1ps
`default_nettype none

module spbh_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  spbh_pkg::point_word_type   push_word,
   output logic                       full,
   input  wire                        pop,
   output logic                       pop_valid,
   output spbh_pkg::point_word_type   pop_word
);

   spbh_pkg::point_word_type mem_ff [spbh_pkg::QUEUE_DEPTH];
   logic [spbh_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [spbh_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [spbh_pkg::QCNT_W-1:0] fill_ff, fill_in;
   logic do_push;
   logic do_pop;

   assign full      = (fill_ff == spbh_pkg::QCNT_W'(spbh_pkg::QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_word  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + spbh_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + spbh_pkg::QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + spbh_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - spbh_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// File: rtl/spbh_slicer.sv
// Back end: takes sorted points from the queue, assigns slice numbers and
// holds each result word in an output register. Depends on spbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spbh_slicer (
   input  wire                                clock,
   input  wire                                reset,
   input  wire [spbh_pkg::THICK_W-1:0]        thickness,
   input  wire                                q_valid,
   input  spbh_pkg::point_word_type           q_word,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output spbh_pkg::rsp_word_type             rsp_data
);

   localparam int DIFF_W = spbh_pkg::HEIGHT_W + 1;

   logic                              rsp_valid_ff, rsp_valid_in;
   spbh_pkg::rsp_word_type            rsp_data_ff, rsp_data_in;
   logic                              first_ff, first_in;
   logic signed [spbh_pkg::HEIGHT_W-1:0] open_ff, open_in;
   logic [spbh_pkg::SLICE_W-1:0]      slice_ff, slice_in;

   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] limit;
   logic                     opens;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Take a word when the output register is empty or being emptied.
   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   // Exact height gap to the slice's opening point, in one extra bit.
   assign diff  = {q_word.height[spbh_pkg::HEIGHT_W-1], q_word.height}
                - {open_ff[spbh_pkg::HEIGHT_W-1], open_ff};
   assign limit = $signed({2'b00, thickness});
   assign opens = first_ff || (diff > limit);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      first_in     = first_ff;
      open_in      = open_ff;
      slice_in     = slice_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
         if (first_ff) begin
            slice_in = '0;
         end else if (opens) begin
            slice_in = slice_ff + spbh_pkg::SLICE_W'(1);
         end
         if (opens) begin
            open_in = q_word.height;
         end
         first_in                   = q_word.last;
         rsp_data_in.point_index    = q_word.index;
         rsp_data_in.slice_number   = slice_in;
         rsp_data_in.slice_start    = opens;
         rsp_data_in.points_dropped = q_word.dropped;
         rsp_data_in.last_result    = q_word.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      open_ff     <= open_in;
      slice_ff    <= slice_in;
   end

endmodule

`default_nettype wire

// File: rtl/slice_points_by_height.sv
// Top level of the height slicer: configuration register, sorting chain,
// queue and slicer. Depends on spbh_pkg, spbh_sorter, spbh_queue, spbh_slicer.
//
// Usage. Points arrive on the req_ channel, one word each, numbered by
// arrival from 0. Up to MAX_POINTS are kept; later points of the set are
// dropped and flagged. A word with last_point set closes the set. The set
// then comes out on the rsp_ channel in order of ascending height (ties in
// arrival order), one word per point, each with its slice number.
// While loading, a point is taken every cycle and enters the sorting chain.
// After the last point, req_stall stays high while the chain shifts out
// one point per cycle whenever the queue has space, through the single
// shift-out port of the chain. The first result word passes through the
// queue and then the output register before it is valid.
// A stall on rsp_ holds the output word; the queue fills and then the chain
// pauses, without loss. Reset empties the chain and queue and sets the
// thickness register to 6554. Write the thickness only while idle.
`timescale 1ns / 1ps
`default_nettype none

module slice_points_by_height #(
   parameter int MAX_POINTS = spbh_pkg::MAX_POINTS
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   input  spbh_pkg::req_word_type              req_data,
   output logic                                req_stall,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output spbh_pkg::rsp_word_type              rsp_data,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire [spbh_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire [spbh_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [spbh_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [spbh_pkg::THICK_W-1:0] thick_ff, thick_in;
   logic                         q_push;
   logic                         q_full;
   logic                         q_pop;
   logic                         q_valid;
   spbh_pkg::point_word_type     q_in_word;
   spbh_pkg::point_word_type     q_out_word;

   // Configuration register.
   assign csr_pready = 1'b1;

   always_comb begin
      thick_in = thick_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr == spbh_pkg::ADDR_THICKNESS) begin
         thick_in = csr_pwdata[spbh_pkg::THICK_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr == spbh_pkg::ADDR_THICKNESS) begin
         csr_prdata = {1'b0, thick_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thick_ff <= spbh_pkg::THICKNESS_RESET;
      end else begin
         thick_ff <= thick_in;
      end
   end

   // Front end: sorting chain.
   spbh_sorter #(
      .MAX_POINTS (MAX_POINTS)
   ) u_sorter (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_word    (q_in_word)
   );

   // Queue between the two halves.
   spbh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_in_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_word  (q_out_word)
   );

   // Back end: slice numbering and output register.
   spbh_slicer u_slicer (
      .clock     (clock),
      .reset     (reset),
      .thickness (thick_ff),
      .q_valid   (q_valid),
      .q_word    (q_out_word),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
